@@ rtl/btlv_pkg.sv @@
// ----------------------------------------------------------------------------
// btlv_pkg : shared types and codes of the BER TLV header decoder
// Result record, status codes and field widths.
// ----------------------------------------------------------------------------
package btlv_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned StatW = 2;

  localparam logic [StatW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatW-1:0] STATUS_TRUNCATED = 2'd1;
  localparam logic [StatW-1:0] STATUS_TOO_LONG  = 2'd2;
  localparam logic [StatW-1:0] STATUS_NO_EOC    = 2'd3;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [1:0]       tag_class;
    logic             constructed;
    logic [WordW-1:0] tag_number;
    logic [WordW-1:0] content_length;
    logic             indefinite;
    logic [WordW-1:0] header_length;
  } result_t;

endpackage

@@ rtl/btlv_core.sv @@
// ----------------------------------------------------------------------------
// btlv_core : header parser
// Per-beat phase update of the identifier and length parser; forms the
// result record on the final beat and returns to the identifier phase.
// ----------------------------------------------------------------------------
module btlv_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          beat_acc,
  input  logic [btlv_pkg::ByteW-1:0]    in_byte,
  input  logic                          in_last,
  output logic                          res_valid,
  output btlv_pkg::result_t             res
);

  localparam logic [2:0] PH_IDENT   = 3'd0;
  localparam logic [2:0] PH_LONGTAG = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_LENOCTS = 3'd3;
  localparam logic [2:0] PH_CONTENT = 3'd4;
  localparam logic [2:0] PH_INDEF   = 3'd5;

  localparam logic [btlv_pkg::WordW-1:0] POS_MAX = '1;

  logic [2:0]                 phase_r, phase_nxt;
  logic [btlv_pkg::WordW-1:0] tag_r, tag_nxt;
  logic [btlv_pkg::WordW-1:0] len_r, len_nxt;
  logic [6:0]                 left_r, left_nxt;
  logic [btlv_pkg::WordW-1:0] pos_r, pos_nxt;
  logic [btlv_pkg::WordW-1:0] hend_r, hend_nxt;
  logic [2:0]                 cf_r, cf_nxt;
  logic                       indef_r, indef_nxt;
  logic                       prevz_r, prevz_nxt;
  logic                       eocf_r, eocf_nxt;
  logic [btlv_pkg::WordW-1:0] eoco_r, eoco_nxt;

  logic                       byte_zero;
  logic [btlv_pkg::WordW-1:0] content_seen;

  assign byte_zero    = (in_byte == '0);
  assign content_seen = pos_nxt - hend_nxt;

  // phase update for one beat
  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    hend_nxt  = hend_r;
    cf_nxt    = cf_r;
    indef_nxt = indef_r;
    prevz_nxt = prevz_r;
    eocf_nxt  = eocf_r;
    eoco_nxt  = eoco_r;
    pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + {{(btlv_pkg::WordW-1){1'b0}}, 1'b1};
    unique case (phase_r)
      PH_LONGTAG: begin
        tag_nxt = {tag_r[btlv_pkg::WordW-8:0], in_byte[6:0]};
        if (!in_byte[7]) begin
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        hend_nxt = pos_nxt;
        if (!in_byte[7]) begin
          len_nxt   = {{(btlv_pkg::WordW-btlv_pkg::ByteW){1'b0}}, in_byte};
          phase_nxt = PH_CONTENT;
        end else if (in_byte[6:0] == 7'd0) begin
          indef_nxt = 1'b1;
          prevz_nxt = 1'b0;
          eocf_nxt  = 1'b0;
          phase_nxt = PH_INDEF;
        end else begin
          left_nxt  = in_byte[6:0];
          len_nxt   = '0;
          phase_nxt = PH_LENOCTS;
        end
      end
      PH_LENOCTS: begin
        len_nxt  = {len_r[btlv_pkg::WordW-btlv_pkg::ByteW-1:0], in_byte};
        hend_nxt = pos_nxt;
        left_nxt = left_r - 7'd1;
        if (left_r == 7'd1) begin
          phase_nxt = PH_CONTENT;
        end
      end
      PH_CONTENT: begin
      end
      PH_INDEF: begin
        if (!eocf_r && byte_zero && prevz_r) begin
          eocf_nxt = 1'b1;
          eoco_nxt = pos_r + ~hend_r;
        end
        prevz_nxt = byte_zero;
      end
      default: begin
        cf_nxt = in_byte[7:5];
        if (in_byte[4:0] == 5'h1f) begin
          tag_nxt   = '0;
          phase_nxt = PH_LONGTAG;
        end else begin
          tag_nxt   = {{(btlv_pkg::WordW-5){1'b0}}, in_byte[4:0]};
          phase_nxt = PH_LENGTH;
        end
      end
    endcase
  end

  // result record from the updated state
  always_comb begin
    res             = '0;
    res.tag_class   = cf_nxt[2:1];
    res.constructed = cf_nxt[0];
    res.indefinite  = indef_nxt;
    res.status      = btlv_pkg::STATUS_OK;
    if (phase_nxt == PH_LONGTAG) begin
      res.status = btlv_pkg::STATUS_TRUNCATED;
    end else begin
      res.tag_number = tag_nxt;
      if (phase_nxt == PH_LENGTH) begin
        res.status = btlv_pkg::STATUS_TRUNCATED;
      end else if (phase_nxt == PH_LENOCTS) begin
        res.status = (phase_r == PH_LENGTH && pos_r != POS_MAX) ?
                     btlv_pkg::STATUS_TRUNCATED : btlv_pkg::STATUS_TOO_LONG;
      end else if (phase_nxt == PH_INDEF) begin
        if (eocf_nxt) begin
          res.content_length = eoco_nxt;
        end else begin
          res.status = btlv_pkg::STATUS_NO_EOC;
        end
      end else if (len_nxt > content_seen) begin
        res.status = btlv_pkg::STATUS_TOO_LONG;
      end else begin
        res.content_length = len_nxt;
      end
    end
    if (res.status == btlv_pkg::STATUS_OK) begin
      res.header_length = hend_nxt;
    end else begin
      res.content_length = '0;
    end
  end

  assign res_valid = beat_acc && in_last;

  always_ff @(posedge clk) begin
    if (!rst_n || (beat_acc && in_last)) begin
      phase_r <= PH_IDENT;
      tag_r   <= '0;
      len_r   <= '0;
      left_r  <= '0;
      pos_r   <= '0;
      hend_r  <= '0;
      cf_r    <= '0;
      indef_r <= 1'b0;
      prevz_r <= 1'b0;
      eocf_r  <= 1'b0;
      eoco_r  <= '0;
    end else if (beat_acc) begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      hend_r  <= hend_nxt;
      cf_r    <= cf_nxt;
      indef_r <= indef_nxt;
      prevz_r <= prevz_nxt;
      eocf_r  <= eocf_nxt;
      eoco_r  <= eoco_nxt;
    end
  end

`ifndef SYNTHESIS
  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    beat_acc && in_last |=> phase_r == PH_IDENT && pos_r == '0)
    else $error("parser did not restart after final beat");

  a_start_in_ident: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == '0 |-> phase_r == PH_IDENT)
    else $error("parser left identifier phase without a beat");

  a_eoc_only_indef: assert property (@(posedge clk) disable iff (!rst_n)
    eocf_r |-> phase_r == PH_INDEF && indef_r)
    else $error("end-of-contents seen outside indefinite form");
`endif

endmodule

@@ rtl/btlv_skid.sv @@
// ----------------------------------------------------------------------------
// btlv_skid : result output stage
// Output register with one spare entry so the input side never waits on
// the result handshake combinationally.
// ----------------------------------------------------------------------------
module btlv_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  btlv_pkg::result_t push_data,
  output logic              spare_free,
  output logic              out_valid,
  input  logic              out_ready,
  output btlv_pkg::result_t out_data
);

  logic              out_valid_r;
  btlv_pkg::result_t out_data_r;
  logic              spare_valid_r;
  btlv_pkg::result_t spare_data_r;
  logic              slot_open;

  assign slot_open  = out_ready || !out_valid_r;
  assign spare_free = !spare_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else if (slot_open) begin
      out_valid_r   <= spare_valid_r || push;
      spare_valid_r <= 1'b0;
    end else if (push) begin
      spare_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_open) begin
      out_data_r <= spare_valid_r ? spare_data_r : push_data;
    end else if (push) begin
      spare_data_r <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    spare_valid_r |-> out_valid_r)
    else $error("spare entry held while output empty");
`endif

endmodule

@@ rtl/ber_tlv_header_decoder.sv @@
// ----------------------------------------------------------------------------
// ber_tlv_header_decoder : BER TLV header decoder
// Parses identifier and length octets of one BER object, one octet a beat,
// and reports status and header fields after the final beat.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    in_byte, in_last
//   out      source     out_valid / out_ready  status, class, form, tag,
//                                              content and header length
//
// One octet per cycle while in_ready is high, a rate set by the per-beat
// phase update of the parser; the final result goes to the output register.
// Synchronous active-low reset returns the parser to the identifier phase.
// A stalled result is held in the output stage plus one spare entry;
// in_ready drops only while that spare entry is occupied.
// ----------------------------------------------------------------------------
module ber_tlv_header_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [btlv_pkg::ByteW-1:0]    in_byte,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [btlv_pkg::StatW-1:0]    out_status,
  output logic [1:0]                    out_tag_class,
  output logic                          out_constructed,
  output logic [btlv_pkg::WordW-1:0]    out_tag_number,
  output logic [btlv_pkg::WordW-1:0]    out_content_length,
  output logic                          out_indefinite,
  output logic [btlv_pkg::WordW-1:0]    out_header_length
);

  logic              beat_acc;
  logic              res_valid;
  btlv_pkg::result_t res;
  btlv_pkg::result_t out_data;

  assign beat_acc = in_valid && in_ready;

  btlv_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_acc  (beat_acc),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .res_valid (res_valid),
    .res       (res)
  );

  btlv_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .spare_free (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_status         = out_data.status;
  assign out_tag_class      = out_data.tag_class;
  assign out_constructed    = out_data.constructed;
  assign out_tag_number     = out_data.tag_number;
  assign out_content_length = out_data.content_length;
  assign out_indefinite     = out_data.indefinite;
  assign out_header_length  = out_data.header_length;

endmodule
